// ----- rtl/scaled_glyph_box_renderer_macros.svh -----
// assertion macros shared by the checker of the glyph box renderer
`ifndef SCALED_GLYPH_BOX_RENDERER_MACROS_SVH
`define SCALED_GLYPH_BOX_RENDERER_MACROS_SVH

// property that must hold at every clock edge out of reset
`define SGBR_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// property that must hold in the cycle after a trigger
`define SGBR_NEXT(lbl, trig, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) else $error(msg);

`endif

// ----- rtl/sgbr_pkg.sv -----
// package of the glyph box renderer: types, constants, font rom and lookup functions
package sgbr_pkg;

	// default geometry of the font cell and number of glyphs
	localparam int GLYPH_COLUMNS_DEF = 6;
	localparam int GLYPH_ROWS_DEF    = 8;
	localparam int GLYPH_COUNT_DEF   = 22;

	// fixed rom size and field widths
	localparam int ROM_GLYPHS  = 22;
	localparam int ROM_COLS    = 6;
	localparam int ROW_BITS    = 8;
	localparam int GLYPH_W     = 5;
	localparam int CODE_W      = 8;
	localparam int ORIGIN_W    = 8;
	localparam int SCALE_W     = 4;
	localparam int COORD_W     = 9;
	localparam int MAX_BOXES   = 19;
	localparam int BOX_CNT_W   = 5;
	localparam int MAX_COLS    = 16;
	localparam int COL_ARG_W   = 4;
	localparam int QUEUE_DEPTH = 2;

	// glyph indices of the non-digit characters
	localparam logic [GLYPH_W-1:0] GL_DOT     = 5'd10;
	localparam logic [GLYPH_W-1:0] GL_DEGREE  = 5'd11;
	localparam logic [GLYPH_W-1:0] GL_PERCENT = 5'd12;
	localparam logic [GLYPH_W-1:0] GL_MINUS   = 5'd13;
	localparam logic [GLYPH_W-1:0] GL_T       = 5'd14;
	localparam logic [GLYPH_W-1:0] GL_H       = 5'd15;
	localparam logic [GLYPH_W-1:0] GL_E       = 5'd16;
	localparam logic [GLYPH_W-1:0] GL_M       = 5'd17;
	localparam logic [GLYPH_W-1:0] GL_P       = 5'd18;
	localparam logic [GLYPH_W-1:0] GL_U       = 5'd19;
	localparam logic [GLYPH_W-1:0] GL_I       = 5'd20;
	localparam logic [GLYPH_W-1:0] GL_D       = 5'd21;

	// font rom, one byte per column, bit 0 is the top row
	localparam logic [ROW_BITS-1:0] GLYPH_ROM [ROM_GLYPHS][ROM_COLS] = '{
		'{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E, 8'h00},
		'{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00, 8'h00},
		'{8'h42, 8'h61, 8'h51, 8'h49, 8'h46, 8'h00},
		'{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31, 8'h00},
		'{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10, 8'h00},
		'{8'h27, 8'h45, 8'h45, 8'h45, 8'h39, 8'h00},
		'{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30, 8'h00},
		'{8'h01, 8'h71, 8'h09, 8'h05, 8'h03, 8'h00},
		'{8'h36, 8'h49, 8'h49, 8'h49, 8'h36, 8'h00},
		'{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E, 8'h00},
		'{8'h00, 8'h00, 8'h60, 8'h60, 8'h00, 8'h00},
		'{8'h06, 8'h09, 8'h09, 8'h06, 8'h00, 8'h00},
		'{8'h62, 8'h64, 8'h08, 8'h13, 8'h23, 8'h00},
		'{8'h08, 8'h08, 8'h08, 8'h08, 8'h08, 8'h00},
		'{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01, 8'h00},
		'{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F, 8'h00},
		'{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41, 8'h00},
		'{8'h7F, 8'h02, 8'h04, 8'h02, 8'h7F, 8'h00},
		'{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06, 8'h00},
		'{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F, 8'h00},
		'{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00, 8'h00},
		'{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C, 8'h00}
	};

	// result of the character lookup
	typedef struct packed {
		logic               known;
		logic [GLYPH_W-1:0] idx;
	} glyph_sel_t;

	// one classified character waiting for the back end
	typedef struct packed {
		logic [GLYPH_W-1:0]  glyph;
		logic [ORIGIN_W-1:0] origin_x;
		logic [ORIGIN_W-1:0] origin_y;
		logic [SCALE_W-1:0]  scale;
	} job_t;

	// back end scan states
	typedef enum logic {
		BK_IDLE,
		BK_SCAN
	} back_state_t;

	// map a character code onto its glyph index
	function automatic glyph_sel_t glyph_of(input logic [CODE_W-1:0] code);
		glyph_sel_t s;
		s.known = 1'b1;
		s.idx   = '0;
		case (code) inside
			["0":"9"]: s.idx = GLYPH_W'(code - 8'("0"));
			".":       s.idx = GL_DOT;
			"d":       s.idx = GL_DEGREE;
			"%":       s.idx = GL_PERCENT;
			"-":       s.idx = GL_MINUS;
			"T":       s.idx = GL_T;
			"H":       s.idx = GL_H;
			"E":       s.idx = GL_E;
			"M":       s.idx = GL_M;
			"P":       s.idx = GL_P;
			"U":       s.idx = GL_U;
			"I":       s.idx = GL_I;
			"D":       s.idx = GL_D;
			default:   s.known = 1'b0;
		endcase
		return s;
	endfunction

	// column byte of a glyph, rows beyond the cell height masked off
	function automatic logic [ROW_BITS-1:0] column_bits(
		input logic [GLYPH_W-1:0]   glyph,
		input logic [COL_ARG_W-1:0] col,
		input int                   rows
	);
		logic [ROW_BITS-1:0] m;
		m = ROW_BITS'((9'd1 << rows) - 9'd1);
		if (int'(glyph) >= ROM_GLYPHS || int'(col) >= ROM_COLS)
			return '0;
		return GLYPH_ROM[glyph][col[2:0]] & m;
	endfunction

	// true when no column after col holds a set pixel
	function automatic logic tail_empty(
		input logic [GLYPH_W-1:0]   glyph,
		input logic [COL_ARG_W-1:0] col,
		input int                   cols,
		input int                   rows
	);
		logic e;
		e = 1'b1;
		for (int c = 0; c < MAX_COLS; c++) begin
			if (c > int'(col) && c < cols &&
			    column_bits(glyph, COL_ARG_W'(c), rows) != '0)
				e = 1'b0;
		end
		return e;
	endfunction

endpackage

// ----- rtl/sgbr_intf.sv -----
// channel interfaces of the glyph box renderer: character requests and boxes

// character request channel
interface sgbr_in_if;
	logic                          valid;
	logic                          ready;
	logic [sgbr_pkg::CODE_W-1:0]   char_code;
	logic [sgbr_pkg::ORIGIN_W-1:0] origin_x;
	logic [sgbr_pkg::ORIGIN_W-1:0] origin_y;
	logic [sgbr_pkg::SCALE_W-1:0]  scale;

	modport source (output valid, char_code, origin_x, origin_y, scale, input ready);
	modport sink (input valid, char_code, origin_x, origin_y, scale, output ready);
endinterface

// box result channel
interface sgbr_out_if;
	logic                         valid;
	logic                         ready;
	logic [sgbr_pkg::COORD_W-1:0] box_x;
	logic [sgbr_pkg::COORD_W-1:0] box_y;
	logic [sgbr_pkg::SCALE_W-1:0] box_side;
	logic                         last_box;

	modport source (output valid, box_x, box_y, box_side, last_box, input ready);
	modport sink (input valid, box_x, box_y, box_side, last_box, output ready);
endinterface

// ----- rtl/sgbr_fifo.sv -----
// short job queue between the front end and the back end
module sgbr_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  sgbr_pkg::job_t  push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output sgbr_pkg::job_t  pop_data
);
	localparam int PtrW = (sgbr_pkg::QUEUE_DEPTH > 1) ? $clog2(sgbr_pkg::QUEUE_DEPTH) : 1;
	localparam int CntW = $clog2(sgbr_pkg::QUEUE_DEPTH + 1);

	sgbr_pkg::job_t    slot_q [sgbr_pkg::QUEUE_DEPTH];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;
	logic              do_push;
	logic              do_pop;

	// handshake decode
	assign push_ready = (count_q != CntW'(sgbr_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = slot_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(sgbr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(sgbr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end
endmodule

// ----- rtl/sgbr_front.sv -----
// front end: takes character requests, looks up the glyph and drops unknown codes and glyphs beyond GLYPH_COUNT
module sgbr_front #(
	parameter int GLYPH_COUNT = sgbr_pkg::GLYPH_COUNT_DEF
) (
	sgbr_in_if.sink         glyph_req,
	output logic            job_valid,
	input  logic            job_ready,
	output sgbr_pkg::job_t  job
);
	sgbr_pkg::glyph_sel_t sel;
	logic                 drawable;

	// classify the character code
	assign sel      = sgbr_pkg::glyph_of(glyph_req.char_code);
	assign drawable = sel.known && (int'(sel.idx) < GLYPH_COUNT);

	// a request is taken whenever the queue has room; unknown ones vanish here
	assign glyph_req.ready = job_ready;
	assign job_valid       = glyph_req.valid && drawable;

	// job record for the back end
	always_comb begin
		job.glyph    = sel.idx;
		job.origin_x = glyph_req.origin_x;
		job.origin_y = glyph_req.origin_y;
		job.scale    = glyph_req.scale;
	end
endmodule

// ----- rtl/sgbr_back.sv -----
// back end: walks the glyph column by column and emits one box per set pixel
module sgbr_back #(
	parameter int GLYPH_COLUMNS = sgbr_pkg::GLYPH_COLUMNS_DEF,
	parameter int GLYPH_ROWS    = sgbr_pkg::GLYPH_ROWS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            job_valid,
	output logic            job_ready,
	input  sgbr_pkg::job_t  job,
	sgbr_out_if.source      box_rsp
);
	localparam int ColW = (GLYPH_COLUMNS > 1) ? $clog2(GLYPH_COLUMNS) : 1;
	localparam int RowW = $clog2(sgbr_pkg::ROW_BITS);

	sgbr_pkg::back_state_t              state_q;
	sgbr_pkg::back_state_t              state_nxt;
	logic [sgbr_pkg::GLYPH_W-1:0]       glyph_q;
	logic [ColW-1:0]                    col_q;
	logic [sgbr_pkg::ROW_BITS-1:0]      colbits_q;
	logic [sgbr_pkg::COORD_W-1:0]       x_q;
	logic [sgbr_pkg::ORIGIN_W-1:0]      oy_q;
	logic [sgbr_pkg::SCALE_W-1:0]       sc_q;
	logic [sgbr_pkg::BOX_CNT_W-1:0]     n_q;

	logic                               out_valid_q;
	logic [sgbr_pkg::COORD_W-1:0]       box_x_q;
	logic [sgbr_pkg::COORD_W-1:0]       box_y_q;
	logic [sgbr_pkg::SCALE_W-1:0]       box_side_q;
	logic                               last_box_q;

	logic                               load;
	logic                               scanning;
	logic                               col_empty;
	logic                               col_end;
	logic                               emit;
	logic                               is_last;
	logic [RowW-1:0]                    row;
	logic [sgbr_pkg::ROW_BITS-1:0]      rest;
	logic [RowW+sgbr_pkg::SCALE_W-1:0]  row_off;
	logic [ColW-1:0]                    col_nxt;

	// lowest set row of the current column
	always_comb begin
		row = '0;
		for (int i = sgbr_pkg::ROW_BITS - 1; i >= 0; i--) begin
			if (colbits_q[i])
				row = RowW'(i);
		end
	end

	// pixel and column bookkeeping
	assign rest      = colbits_q & (colbits_q - 1'b1);
	assign col_empty = (colbits_q == '0);
	assign col_end   = (col_q == ColW'(GLYPH_COLUMNS - 1));
	assign col_nxt   = col_q + 1'b1;
	assign row_off   = row * sc_q;
	assign is_last   = ((rest == '0) &&
	                    sgbr_pkg::tail_empty(glyph_q, sgbr_pkg::COL_ARG_W'(col_q),
	                                         GLYPH_COLUMNS, GLYPH_ROWS)) ||
	                   (n_q == sgbr_pkg::BOX_CNT_W'(sgbr_pkg::MAX_BOXES - 1));

	// control outputs per state
	always_comb begin
		job_ready = 1'b0;
		scanning  = 1'b0;
		case (state_q)
			sgbr_pkg::BK_IDLE: job_ready = 1'b1;
			sgbr_pkg::BK_SCAN: scanning  = 1'b1;
			default: ;
		endcase
	end

	assign load = job_valid && job_ready;
	assign emit = scanning && !col_empty && (!out_valid_q || box_rsp.ready);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			sgbr_pkg::BK_IDLE: begin
				if (job_valid)
					state_nxt = sgbr_pkg::BK_SCAN;
			end
			sgbr_pkg::BK_SCAN: begin
				if (emit && is_last)
					state_nxt = sgbr_pkg::BK_IDLE;
				else if (col_empty && col_end)
					state_nxt = sgbr_pkg::BK_IDLE;
			end
			default: state_nxt = sgbr_pkg::BK_IDLE;
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sgbr_pkg::BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (emit)
				out_valid_q <= 1'b1;
			else if (box_rsp.ready)
				out_valid_q <= 1'b0;
		end
	end

	// scan registers
	always_ff @(posedge clk) begin
		if (load) begin
			glyph_q   <= job.glyph;
			col_q     <= '0;
			colbits_q <= sgbr_pkg::column_bits(job.glyph, '0, GLYPH_ROWS);
			x_q       <= sgbr_pkg::COORD_W'(job.origin_x);
			oy_q      <= job.origin_y;
			sc_q      <= job.scale;
			n_q       <= '0;
		end else if (emit) begin
			colbits_q <= rest;
			n_q       <= n_q + 1'b1;
		end else if (scanning && col_empty && !col_end) begin
			col_q     <= col_nxt;
			colbits_q <= sgbr_pkg::column_bits(glyph_q, sgbr_pkg::COL_ARG_W'(col_nxt),
			                                   GLYPH_ROWS);
			x_q       <= x_q + sgbr_pkg::COORD_W'(sc_q);
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (emit) begin
			box_x_q    <= x_q;
			box_y_q    <= sgbr_pkg::COORD_W'(oy_q) + sgbr_pkg::COORD_W'(row_off);
			box_side_q <= sc_q;
			last_box_q <= is_last;
		end
	end

	assign box_rsp.valid    = out_valid_q;
	assign box_rsp.box_x    = box_x_q;
	assign box_rsp.box_y    = box_y_q;
	assign box_rsp.box_side = box_side_q;
	assign box_rsp.last_box = last_box_q;
endmodule

// ----- rtl/scaled_glyph_box_renderer.sv -----
// top level of the scaled glyph box renderer
//
// channel     dir  transaction
// glyph_req   in   char_code, origin_x, origin_y, scale
// box_rsp     out  box_x, box_y, box_side, last_box
//
// one box leaves per cycle while box_rsp does not stall; a character takes a load step, then
// a step per box and a step past each empty column, as set by the scan.
// unknown codes are taken and give no transaction on box_rsp.
// a two-entry job queue lets requests be taken while the scan or box_rsp stalls.
// arst_n clears the queue, the scan state and the box valid; no clearing pass.
module scaled_glyph_box_renderer #(
	parameter int GLYPH_COLUMNS = sgbr_pkg::GLYPH_COLUMNS_DEF,
	parameter int GLYPH_ROWS    = sgbr_pkg::GLYPH_ROWS_DEF,
	parameter int GLYPH_COUNT   = sgbr_pkg::GLYPH_COUNT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	sgbr_in_if.sink    glyph_req,
	sgbr_out_if.source box_rsp
);
	logic           push_valid;
	logic           push_ready;
	sgbr_pkg::job_t push_data;
	logic           pop_valid;
	logic           pop_ready;
	sgbr_pkg::job_t pop_data;

	// classify incoming characters
	sgbr_front #(
		.GLYPH_COUNT (GLYPH_COUNT)
	) u_front (
		.glyph_req (glyph_req),
		.job_valid (push_valid),
		.job_ready (push_ready),
		.job       (push_data)
	);

	// decoupling queue
	sgbr_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// glyph scan and box output
	sgbr_back #(
		.GLYPH_COLUMNS (GLYPH_COLUMNS),
		.GLYPH_ROWS    (GLYPH_ROWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (pop_valid),
		.job_ready (pop_ready),
		.job       (pop_data),
		.box_rsp   (box_rsp)
	);
endmodule

// ----- rtl/sgbr_checker.sv -----
// port checker of the glyph box renderer and its bind
`include "scaled_glyph_box_renderer_macros.svh"

module sgbr_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [sgbr_pkg::COORD_W-1:0] box_x,
	input logic [sgbr_pkg::COORD_W-1:0] box_y,
	input logic [sgbr_pkg::SCALE_W-1:0] box_side,
	input logic                         last_box
);
	logic                         mid_q;
	logic [sgbr_pkg::SCALE_W-1:0] side_q;
	logic [sgbr_pkg::COORD_W-1:0] x_q;

	// track the character currently being drawn
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q <= 1'b0;
		end else if (out_valid && out_ready) begin
			mid_q <= !last_box;
		end
	end

	// side and column of the last box taken
	always_ff @(posedge clk) begin
		if (out_valid && out_ready) begin
			side_q <= box_side;
			x_q    <= box_x;
		end
	end

	// stalled box stays offered
	`SGBR_NEXT(a_valid_held, out_valid && !out_ready, out_valid, "box dropped while stalled")

	// stalled box keeps its payload
	`SGBR_NEXT(a_box_stable, out_valid && !out_ready, $stable(box_x) && $stable(box_y) && $stable(box_side) && $stable(last_box), "box payload changed while stalled")

	// all boxes of one character share the side
	`SGBR_CHECK(a_side_kept, !(mid_q && out_valid) || (box_side == side_q), "box side changed inside a character")

	// columns are scanned left to right
	`SGBR_CHECK(a_x_order, !(mid_q && out_valid) || (box_x >= x_q), "box column went backwards inside a character")
endmodule

bind scaled_glyph_box_renderer sgbr_checker u_sgbr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (box_rsp.valid),
	.out_ready (box_rsp.ready),
	.box_x     (box_rsp.box_x),
	.box_y     (box_rsp.box_y),
	.box_side  (box_rsp.box_side),
	.last_box  (box_rsp.last_box)
);
